/* rtl/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg: shared definitions of the state-space controller
// Field widths, fixed-point formats, item codes and the types that pass
// between the sequencer and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int COEF_W    = 24;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = COEF_W + DATA_W;
  localparam int ACC_W     = 64;
  localparam int FRAC_W    = 16;
  localparam int IDX_W     = 8;
  localparam int OUT_IDX_W = 3;
  localparam int W_COUNT   = 4;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ISSUE  = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_EMIT   = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

endpackage

/* rtl/ssc_if.sv */
// ----------------------------------------------------------------------------
// ssc_if: item channels of the state-space controller
// Valid/ready channels for input items and for control output items.
// ----------------------------------------------------------------------------
interface ssc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [ssc_pkg::IDX_W-1:0]           coef_index;
  logic signed [ssc_pkg::COEF_W-1:0]   coef_value;
  logic signed [ssc_pkg::DATA_W-1:0]   ref_a;
  logic signed [ssc_pkg::DATA_W-1:0]   ref_b;
  logic signed [ssc_pkg::DATA_W-1:0]   meas_a;
  logic signed [ssc_pkg::DATA_W-1:0]   meas_b;

  modport source (output valid, mode, coef_index, coef_value, ref_a, ref_b, meas_a, meas_b,
                  input ready);
  modport sink (input valid, mode, coef_index, coef_value, ref_a, ref_b, meas_a, meas_b,
                output ready);
endinterface

interface ssc_out_if;
  logic                                valid;
  logic                                ready;
  logic [ssc_pkg::OUT_IDX_W-1:0]       out_index;
  logic signed [ssc_pkg::DATA_W-1:0]   out_value;
  logic                                last;

  modport source (output valid, out_index, out_value, last, input ready);
  modport sink (input valid, out_index, out_value, last, output ready);
endinterface

/* rtl/state_space_controller_unit.sv */
// ----------------------------------------------------------------------------
// A sample item gives its first output once row 0 has been issued term by term, drained
// through the multiply-accumulate unit and registered. A load item with an index in range
// is written to the coefficient memory as it is accepted; a sample item keeps the block busy,
// taking no new item, until all its rows have passed the one shared multiply-accumulate unit.
// Reset clears the controller state through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// state_space_controller_unit: discrete state-space controller
// Coefficients and a double-buffered state vector live in memories; a
// sequencer streams one row at a time through a shared multiply-accumulate.
// ----------------------------------------------------------------------------
module state_space_controller_unit #(
  parameter int STATE_COUNT = 12,
  parameter int OUT_COUNT   = 2,
  parameter int COEF_DEPTH  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssc_in_if.sink      in_i,
  ssc_out_if.source   out_o
);

  localparam int WC     = ssc_pkg::W_COUNT;
  localparam int DW     = ssc_pkg::DATA_W;
  localparam int B_BASE = STATE_COUNT * STATE_COUNT;
  localparam int C_BASE = B_BASE + STATE_COUNT * WC;
  localparam int D_BASE = C_BASE + OUT_COUNT * STATE_COUNT;
  localparam int TOTAL  = D_BASE + OUT_COUNT * WC;
  localparam int PW     = $clog2(TOTAL + COEF_DEPTH + (1 << ssc_pkg::IDX_W));
  localparam int CAW    = $clog2(COEF_DEPTH);
  localparam int SDEPTH = 2 * STATE_COUNT;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int TERMS  = STATE_COUNT + WC;
  localparam int ROWS   = STATE_COUNT + OUT_COUNT;
  localparam int KW     = $clog2(TERMS);
  localparam int RW     = $clog2(ROWS);

  ssc_pkg::seq_state_e state_d, state_q;
  logic [KW-1:0]       k_d, k_q;
  logic [RW-1:0]       row_d, row_q;
  logic [PW-1:0]       xbase_d, xbase_q;
  logic [PW-1:0]       wbase_d, wbase_q;
  logic                bank_d, bank_q;
  logic [SDEPTH-1:0]   svalid_d, svalid_q;
  logic signed [DW-1:0] w_d [WC];
  logic signed [DW-1:0] w_q [WC];

  ssc_pkg::mac_ctl_t   s1_ctl_d, s1_ctl_q;
  logic                s1_wterm_q, s1_czero_q, s1_xzero_q;
  logic [1:0]          s1_widx_q;

  logic [ssc_pkg::OUT_IDX_W-1:0] out_index_d, out_index_q;
  logic signed [DW-1:0] out_value_d, out_value_q;
  logic                out_last_d, out_last_q;

  logic                in_fire, out_fire, load_ok;
  logic                is_wterm, czero, xzero;
  logic [KW-1:0]       wdiff;
  logic [1:0]          widx;
  logic [PW-1:0]       pos;
  logic [SAW-1:0]      s_raddr, s_waddr;
  logic [RW-1:0]       srow;
  logic                c_we, s_we, rd_en;
  logic [ssc_pkg::COEF_W-1:0] c_rdata;
  logic [DW-1:0]       s_rdata;
  logic signed [ssc_pkg::COEF_W-1:0] mac_coef;
  logic signed [DW-1:0] mac_data;
  logic signed [DW-1:0] mac_result;
  logic                mac_busy;
  logic signed [DW:0]  err_a, err_b;

  function automatic logic signed [DW-1:0] sat_err(input logic signed [DW:0] v);
    logic signed [DW-1:0] r;
    if (v[DW] != v[DW-1]) begin
      r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  assign in_i.ready = (state_q == ssc_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign load_ok    = PW'(in_i.coef_index) < PW'(COEF_DEPTH);

  assign err_a = (DW + 1)'(in_i.ref_a) - (DW + 1)'(in_i.meas_a);
  assign err_b = (DW + 1)'(in_i.ref_b) - (DW + 1)'(in_i.meas_b);

  // Address generation for the term being issued.
  assign is_wterm = k_q >= KW'(STATE_COUNT);
  assign wdiff    = k_q - KW'(STATE_COUNT);
  assign widx     = wdiff[1:0];
  assign pos      = is_wterm ? (wbase_q + PW'(widx)) : (xbase_q + PW'(k_q));
  assign czero    = pos >= PW'(COEF_DEPTH);
  assign s_raddr  = bank_q ? (SAW'(STATE_COUNT) + SAW'(k_q)) : SAW'(k_q);
  assign xzero    = is_wterm || !svalid_q[s_raddr];
  assign rd_en    = (state_q == ssc_pkg::ST_ISSUE);

  assign srow    = row_q - RW'(OUT_COUNT);
  assign s_waddr = bank_q ? SAW'(srow) : (SAW'(STATE_COUNT) + SAW'(srow));

  assign c_we = in_fire && (in_i.mode == ssc_pkg::MODE_LOAD) && load_ok;

  ssc_ram #(.WIDTH(ssc_pkg::COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (CAW'(in_i.coef_index)),
    .wdata_i (in_i.coef_value),
    .re_i    (rd_en),
    .raddr_i (pos[CAW-1:0]),
    .rdata_o (c_rdata)
  );

  ssc_ram #(.WIDTH(DW), .DEPTH(SDEPTH)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (mac_result),
    .re_i    (rd_en),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign mac_coef = s1_czero_q ? '0 : c_rdata;
  assign mac_data = s1_wterm_q ? w_q[s1_widx_q] : (s1_xzero_q ? '0 : s_rdata);

  ssc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s1_ctl_q),
    .coef_i   (mac_coef),
    .data_i   (mac_data),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    row_d       = row_q;
    xbase_d     = xbase_q;
    wbase_d     = wbase_q;
    bank_d      = bank_q;
    svalid_d    = svalid_q;
    w_d         = w_q;
    s1_ctl_d    = '0;
    out_index_d = out_index_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    s_we        = 1'b0;
    unique case (state_q)
      ssc_pkg::ST_IDLE: begin
        if (in_fire && (in_i.mode == ssc_pkg::MODE_SAMPLE)) begin
          w_d[0]  = sat_err(err_a);
          w_d[1]  = sat_err(err_b);
          w_d[2]  = in_i.meas_a;
          w_d[3]  = in_i.meas_b;
          k_d     = '0;
          row_d   = '0;
          xbase_d = PW'(C_BASE);
          wbase_d = PW'(D_BASE);
          state_d = ssc_pkg::ST_ISSUE;
        end
      end
      ssc_pkg::ST_ISSUE: begin
        s1_ctl_d.valid = 1'b1;
        s1_ctl_d.first = (k_q == '0);
        if (k_q == KW'(TERMS - 1)) begin
          state_d = ssc_pkg::ST_DRAIN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ssc_pkg::ST_DRAIN: begin
        if (!s1_ctl_q.valid && !mac_busy) begin
          state_d = ssc_pkg::ST_FINISH;
        end
      end
      ssc_pkg::ST_FINISH: begin
        if (row_q < RW'(OUT_COUNT)) begin
          out_index_d = ssc_pkg::OUT_IDX_W'(row_q);
          out_value_d = mac_result;
          out_last_d  = (row_q == RW'(OUT_COUNT - 1));
          state_d     = ssc_pkg::ST_EMIT;
        end else begin
          s_we              = 1'b1;
          svalid_d[s_waddr] = 1'b1;
        end
      end
      ssc_pkg::ST_EMIT: begin
      end
      default: begin
        state_d = ssc_pkg::ST_IDLE;
      end
    endcase

    // Step to the next row once the current one has been delivered or stored.
    if ((state_q == ssc_pkg::ST_EMIT && out_fire) ||
        (state_q == ssc_pkg::ST_FINISH && row_q >= RW'(OUT_COUNT))) begin
      if (row_q == RW'(ROWS - 1)) begin
        bank_d  = !bank_q;
        state_d = ssc_pkg::ST_IDLE;
      end else begin
        row_d   = row_q + RW'(1);
        k_d     = '0;
        state_d = ssc_pkg::ST_ISSUE;
        if (row_q == RW'(OUT_COUNT - 1)) begin
          xbase_d = '0;
          wbase_d = PW'(B_BASE);
        end else begin
          xbase_d = xbase_q + PW'(STATE_COUNT);
          wbase_d = wbase_q + PW'(WC);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ssc_pkg::ST_IDLE;
      k_q      <= '0;
      row_q    <= '0;
      bank_q   <= 1'b0;
      svalid_q <= '0;
      s1_ctl_q <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      row_q    <= row_d;
      bank_q   <= bank_d;
      svalid_q <= svalid_d;
      s1_ctl_q <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xbase_q     <= xbase_d;
    wbase_q     <= wbase_d;
    w_q         <= w_d;
    s1_wterm_q  <= is_wterm;
    s1_widx_q   <= widx;
    s1_czero_q  <= czero;
    s1_xzero_q  <= xzero;
    out_index_q <= out_index_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid     = (state_q == ssc_pkg::ST_EMIT);
  assign out_o.out_index = out_index_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;

endmodule

/* rtl/ssc_ram.sv */
// ----------------------------------------------------------------------------
// ssc_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module ssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ssc_mac.sv */
// ----------------------------------------------------------------------------
// ssc_mac: shared multiply-accumulate unit
// Registered Q8.16 by Q16.16 product, exact wide accumulator, and rounding
// with saturation of the accumulated row to signed Q16.16.
// ----------------------------------------------------------------------------
module ssc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssc_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [ssc_pkg::COEF_W-1:0]  coef_i,
  input  logic signed [ssc_pkg::DATA_W-1:0]  data_i,
  output logic                               busy_o,
  output logic signed [ssc_pkg::DATA_W-1:0]  result_o
);

  localparam int AW = ssc_pkg::ACC_W;
  localparam int DW = ssc_pkg::DATA_W;

  ssc_pkg::mac_ctl_t           ctl_q;
  logic signed [ssc_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [AW-1:0]        acc_d, acc_q;
  logic signed [AW-1:0]        rnd;
  logic signed [AW-1:0]        quo;
  logic                        fits;

  assign prod_d = coef_i * data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_q.valid) begin
      if (ctl_q.first) begin
        acc_d = AW'(prod_q);
      end else begin
        acc_d = acc_q + AW'(prod_q);
      end
    end
  end

  // Round half up, floor shift, then clamp to the signed 32-bit range.
  always_comb begin
    rnd  = acc_q + AW'(1 << (ssc_pkg::FRAC_W - 1));
    quo  = rnd >>> ssc_pkg::FRAC_W;
    fits = (&quo[AW-1:DW-1]) || !(|quo[AW-1:DW-1]);
    if (fits) begin
      result_o = quo[DW-1:0];
    end else if (quo[AW-1]) begin
      result_o = {1'b1, {(DW-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign busy_o = ctl_q.valid;

endmodule

/* rtl/ssc_checker.sv */
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks of the state-space controller
// Watches the item channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module ssc_checker #(
  parameter int OUT_COUNT = 2
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                in_mode_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [ssc_pkg::OUT_IDX_W-1:0]       out_index_i,
  input logic [ssc_pkg::DATA_W-1:0]          out_value_i,
  input logic                                out_last_i
);

  // A stalled output item holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
    $stable(out_index_i) && $stable(out_last_i))
    else $error("Output item changed while stalled.");

  // The block never takes an input item while an output item is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("Input ready while an output item is pending.");

  // The last flag marks exactly the final output of a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_index_i == ssc_pkg::OUT_IDX_W'(OUT_COUNT - 1))))
    else $error("Last flag does not match the output index.");

  // An accepted sample keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == ssc_pkg::MODE_SAMPLE) |=> !in_ready_i)
    else $error("Input ready right after a sample item.");

  // After an output that is not the last, the sample is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> !in_ready_i)
    else $error("Input ready before the sample finished.");

endmodule

bind state_space_controller_unit ssc_checker #(.OUT_COUNT(OUT_COUNT)) u_ssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.out_index),
  .out_value_i (out_o.out_value),
  .out_last_i  (out_o.last)
);
